// File: hdl/difmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// difmt_pkg: shared types and constants of the decimal field formatter
// Item layouts, the job record passed from the converter to the emitter and
// the ASCII codes used to build a field.
// ----------------------------------------------------------------------------
package difmt_pkg;

  localparam int unsigned NUM_DIGITS  = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned CNT_W       = 7;   // field position and length counters
  localparam int unsigned BITS_PER_CY = 4;   // magnitude bits consumed per cycle
  localparam int unsigned CONV_CYCLES = 32 / BITS_PER_CY;
  localparam int unsigned CONV_CNT_W  = $clog2(CONV_CYCLES);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic signed [31:0] value;
    logic [6:0]         field_width;
    logic [5:0]         min_digits;
    logic               left_justify;
  } fmt_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } fmt_out_t;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // one converted item waiting for emission, width and precision saturated
  typedef struct packed {
    bcd_t       digits;
    logic [3:0] num_digits;
    logic       neg;
    logic [6:0] width;
    logic [5:0] prec;
    logic       left;
  } fmt_job_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_e;

  typedef enum logic {
    BS_IDLE,
    BS_EMIT
  } back_state_e;

endpackage
`default_nettype wire

// File: hdl/difmt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// difmt_front: input stage and binary to decimal converter
// Takes one item, forms the magnitude and converts it to BCD four bits per
// cycle by shift and add-3, then pushes a job record into the queue.
// ----------------------------------------------------------------------------
module difmt_front #(
  parameter int MAX_FIELD = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  difmt_pkg::fmt_in_t     in_data_i,
  output logic                   job_valid_o,
  input  wire                    job_ready_i,
  output difmt_pkg::fmt_job_t    job_o
);
  import difmt_pkg::*;

  localparam logic [6:0] MaxWidth = 7'(MAX_FIELD);
  localparam logic [5:0] MaxPrec  = 6'(MAX_FIELD - 1);

  front_state_e          state_q, state_d;
  logic [CONV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]           mag_q, mag_d;
  bcd_t                  bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic [6:0]            width_q, width_d;
  logic [5:0]            prec_q, prec_d;
  logic                  left_q, left_d;
  logic [3:0]            nd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
    width_q <= width_d;
    prec_q  <= prec_d;
    left_q  <= left_d;
  end

  always_comb begin
    bcd_t       b;
    logic [31:0] m;
    logic [4*NUM_DIGITS-1:0] bf;
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    width_d = width_q;
    prec_d  = prec_q;
    left_d  = left_q;
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    b = bcd_q;
    m = mag_q;
    bf = '0;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          neg_d   = in_data_i.value[31];
          mag_d   = in_data_i.value[31] ? (32'd0 - 32'(in_data_i.value))
                                        : 32'(in_data_i.value);
          width_d = (in_data_i.field_width > MaxWidth) ? MaxWidth
                                                       : in_data_i.field_width;
          prec_d  = (in_data_i.min_digits > MaxPrec) ? MaxPrec
                                                     : in_data_i.min_digits;
          left_d  = in_data_i.left_justify;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = FS_CONV;
        end
      end
      FS_CONV: begin
        // shift and add-3, msb of the magnitude first
        for (int s = 0; s < BITS_PER_CY; s++) begin
          for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[d] >= 4'd5) b[d] = b[d] + 4'd3;
          end
          bf = b;
          b  = {bf[4*NUM_DIGITS-2:0], m[31]};
          m  = {m[30:0], 1'b0};
        end
        bcd_d = b;
        mag_d = m;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CONV_CNT_W'(CONV_CYCLES - 1)) state_d = FS_PUSH;
      end
      FS_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // count of significant digits, zero for a zero magnitude
  always_comb begin
    nd = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_q[d] != 4'd0) nd = 4'(d + 1);
    end
  end

  always_comb begin
    job_o.digits     = bcd_q;
    job_o.num_digits = nd;
    job_o.neg        = neg_q;
    job_o.width      = width_q;
    job_o.prec       = prec_q;
    job_o.left       = left_q;
  end

endmodule
`default_nettype wire

// File: hdl/difmt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// difmt_queue: short job queue
// Small register queue between the converter and the emitter so that each
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
module difmt_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_valid_i,
  output logic                   push_ready_o,
  input  difmt_pkg::fmt_job_t    push_data_i,
  output logic                   pop_valid_o,
  input  wire                    pop_ready_i,
  output difmt_pkg::fmt_job_t    pop_data_o
);
  import difmt_pkg::*;

  fmt_job_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// File: hdl/difmt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// difmt_back: field emitter
// Lays out a job as padding, sign, precision zeros and digits, padding last
// if left-justified; sends one char per cycle unless stalled, from a register.
// ----------------------------------------------------------------------------
module difmt_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    job_valid_i,
  output logic                   job_ready_o,
  input  difmt_pkg::fmt_job_t    job_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output difmt_pkg::fmt_out_t    out_data_o
);
  import difmt_pkg::*;

  back_state_e      state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] body_start_q, body_start_d;
  logic [CNT_W-1:0] body_end_q, body_end_d;
  logic [5:0]       zeros_q, zeros_d;
  logic [3:0]       nd_q, nd_d;
  logic             neg_q, neg_d;
  bcd_t             digits_q, digits_d;
  logic             out_valid_q, out_valid_d;
  fmt_out_t         out_q, out_d;

  // layout of the job at the queue head
  logic [CNT_W-1:0] ndig, body, total, pad;

  // character at the current position
  logic [CNT_W-1:0] rel, dpos, pdig;
  logic [3:0]       idx;
  logic [7:0]       ch;
  logic             advance;

  always_comb begin
    ndig  = (CNT_W'(job_i.num_digits) > CNT_W'(job_i.prec)) ? CNT_W'(job_i.num_digits)
                                                           : CNT_W'(job_i.prec);
    body  = ndig + CNT_W'(job_i.neg);
    total = (body > job_i.width) ? body : job_i.width;
    pad   = total - body;
  end

  always_comb begin
    rel  = k_q - body_start_q;
    dpos = rel - CNT_W'(neg_q);
    pdig = dpos - CNT_W'(zeros_q);
    idx  = nd_q - 4'd1 - pdig[3:0];
    if (k_q < body_start_q || k_q >= body_end_q) ch = CH_SPACE;
    else if (neg_q && rel == '0) ch = CH_MINUS;
    else if (dpos < CNT_W'(zeros_q)) ch = CH_ZERO;
    else ch = CH_ZERO + {4'b0, digits_q[idx]};
  end

  assign advance = (state_q == BS_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    total_d      = total_q;
    body_start_d = body_start_q;
    body_end_d   = body_end_q;
    zeros_d      = zeros_q;
    nd_d         = nd_q;
    neg_d        = neg_q;
    digits_d     = digits_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    job_ready_o  = 1'b0;
    case (state_q)
      BS_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          k_d          = '0;
          total_d      = total;
          body_start_d = job_i.left ? '0 : pad;
          body_end_d   = (job_i.left ? '0 : pad) + body;
          zeros_d      = 6'(ndig - CNT_W'(job_i.num_digits));
          nd_d         = job_i.num_digits;
          neg_d        = job_i.neg;
          digits_d     = job_i.digits;
          // an empty field is dropped here
          if (total != '0) state_d = BS_EMIT;
        end
      end
      BS_EMIT: begin
        if (advance) begin
          out_valid_d     = 1'b1;
          out_d.out_char  = ch;
          out_d.last_char = (k_q == total_q - 1'b1);
          k_d             = k_q + 1'b1;
          if (k_q == total_q - 1'b1) state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    total_q      <= total_d;
    body_start_q <= body_start_d;
    body_end_q   <= body_end_d;
    zeros_q      <= zeros_d;
    nd_q         <= nd_d;
    neg_q        <= neg_d;
    digits_q     <= digits_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: hdl/decimal_integer_field_formatter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_integer_field_formatter_core: printf %d field formatter
// Turns a signed 32-bit value, field width, precision and justify flag into
// a run of ASCII characters with the final one marked.
//
// Input channel in_valid_i/in_ready_o carries one item per field. Output
// channel out_valid_o/out_ready_i carries one character per transfer, with
// last_char set on the final character. A zero value with zero precision
// and zero width yields no characters at all.
// The front converts the magnitude to BCD four bits per cycle, then hands
// the job to a two-entry queue. The back loads a job, then sends one
// character per cycle while the receiver accepts them. Conversion of the
// next item runs while the previous field is sent.
// Reset empties the queue, returns both sides to idle and drops the output
// valid. When the receiver stalls, the back holds its character, the queue
// fills and in_ready_o drops until space frees up.
// ----------------------------------------------------------------------------
module decimal_integer_field_formatter_core #(
  parameter int MAX_FIELD = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  difmt_pkg::fmt_in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output difmt_pkg::fmt_out_t  out_data_o
);
  import difmt_pkg::*;

  logic     push_valid, push_ready;
  fmt_job_t push_job;
  logic     pop_valid, pop_ready;
  fmt_job_t pop_job;

  difmt_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o      (push_job)
  );

  difmt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_job)
  );

  difmt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the printf %d field formatter
// Feeds fields through the valid/ready input, predicts or lists every character of
// each formatted field and checks the output stream character by character,
// with random gaps and stalls on both sides and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
  import difmt_pkg::*;

  localparam int FIELD_MAX    = 64;
  localparam int RANDOM_ITEMS = 146;
  localparam int PAUSE_AT     = 80;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT_CHAR = 120;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fmt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fmt_out_t out_data;

  fmt_out_t pending_chars[$];
  fmt_in_t  dir_items[$];
  string    dir_texts[$];
  int       mismatches = 0;
  int       chars_seen = 0;
  int       idle_cycles = 0;

  decimal_integer_field_formatter_core #(
    .MAX_FIELD(FIELD_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 20) begin
      $display("mismatch @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  // expected characters of one field, built as text then marked
  function automatic void predict_field(input fmt_in_t req);
    logic [7:0] text_q[$];
    logic [31:0] mag;
    int width;
    int prec;
    fmt_out_t c;
    width = (req.field_width > FIELD_MAX) ? FIELD_MAX : int'(req.field_width);
    prec  = (req.min_digits > FIELD_MAX - 1) ? FIELD_MAX - 1 : int'(req.min_digits);
    mag   = req.value[31] ? (~req.value + 32'd1) : req.value;
    while (mag != 0) begin
      text_q.push_front(CH_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end
    while (text_q.size() < prec) text_q.push_front(CH_ZERO);
    if (req.value[31]) text_q.push_front(CH_MINUS);
    while (text_q.size() < width) begin
      if (req.left_justify) text_q.push_back(CH_SPACE);
      else text_q.push_front(CH_SPACE);
    end
    foreach (text_q[k]) begin
      c.out_char  = text_q[k];
      c.last_char = (k == text_q.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void expect_text(input string s);
    fmt_out_t c;
    for (int k = 0; k < s.len(); k++) begin
      c.out_char  = s[k];
      c.last_char = (k == s.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic fmt_in_t field_req(input logic [31:0] v, input int w, input int p,
                                        input bit l);
    fmt_in_t r;
    r.value        = v;
    r.field_width  = 7'(w);
    r.min_digits   = 6'(p);
    r.left_justify = l;
    return r;
  endfunction

  // "?" means the characters come from the predictor
  task automatic add_row(input logic [31:0] v, input int w, input int p, input bit l,
                         input string text);
    dir_items.push_back(field_req(v, w, p, l));
    dir_texts.push_back(text);
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: v = -32'($urandom_range(1, 999));
      3: v = '0;
      4: case ($urandom_range(0, 3))
           0: v = 32'h8000_0000;
           1: v = 32'h7fff_ffff;
           2: v = 32'hffff_ffff;
           default: v = 32'd1;
         endcase
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic fmt_in_t rand_item();
    int w;
    int p;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 16);
    p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
    return field_req(rand_value(), w, p, $urandom_range(0, 1));
  endfunction

  // valid stays up across back-to-back items, dropped only for a gap
  task automatic send_item(input fmt_in_t req, input string text, input bit quiet);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    if (text == "?") predict_field(req);
    else expect_text(text);
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // receiver: check accepted item, then pick next ready
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ready && out_valid === 1'b1) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h with nothing pending", out_data.out_char));
        end else begin
          if (out_data.out_char !== pending_chars[0].out_char)
            report_mismatch($sformatf("char %0d: got 0x%02h want 0x%02h", chars_seen,
                                      out_data.out_char, pending_chars[0].out_char));
          if (out_data.last_char !== pending_chars[0].last_char)
            report_mismatch($sformatf("char %0d: last got %b want %b", chars_seen,
                                      out_data.last_char, pending_chars[0].last_char));
          void'(pending_chars.pop_front());
        end
      end
      if (!long_hold_done && chars_seen >= HOLD_AT_CHAR) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        // every third stretch of characters runs with no stalls
        if ((chars_seen / 100) % 3 != 1) stall_left = gap_len();
        out_ready <= (stall_left == 0);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    fmt_in_t req;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(32'd0,          0,   1,  0, "0");
    add_row(32'd0,          0,   0,  0, "");
    add_row(32'd0,          5,   0,  0, "     ");
    add_row(32'd0,          5,   0,  1, "     ");
    add_row(32'd0,          1,   0,  1, " ");
    add_row(32'h7fff_ffff,  0,   1,  0, "2147483647");
    add_row(32'h8000_0000,  0,   1,  0, "-2147483648");
    add_row(32'hffff_ffff,  0,   1,  0, "-1");
    add_row(32'd100,        0,   1,  0, "100");
    add_row(32'd42,         6,   1,  0, "    42");
    add_row(32'd42,         6,   1,  1, "42    ");
    add_row(-32'd42,        6,   4,  0, " -0042");
    add_row(-32'd42,        6,   4,  1, "-0042 ");
    add_row(32'd7,          127, 1,  0, "?");
    add_row(32'd7,          127, 1,  1, "?");
    add_row(-32'd5,         0,   63, 0, "?");
    add_row(32'd5,          0,   63, 1, "?");
    add_row(32'h8000_0000,  64,  63, 1, "?");
    add_row(32'd1000000000, 12,  11, 0, "?");
    add_row(32'd0,          64,  0,  0, "?");
    add_row(32'd0,          0,   63, 0, "?");
    add_row(32'd123456789,  10,  10, 1, "?");
    add_row(32'h5555_5555,  96,  20, 0, "?");
    add_row(32'haaaa_aaaa,  33,  42, 1, "?");
    foreach (dir_items[i]) send_item(dir_items[i], dir_texts[i], 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending_chars.size() != 0);
      end
      req = rand_item();
      send_item(req, "?", (i / 25) % 3 == 1);
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/difmt_pkg.sv
hdl/difmt_front.sv
hdl/difmt_queue.sv
hdl/difmt_back.sv
hdl/decimal_integer_field_formatter_core.sv
tb/tb_top.sv
